/* design/mul_div_unit_with_error_flags_assert.svh */
// assertion macros for the multiply/divide unit
// no dependencies; included by the top level
`ifndef MUL_DIV_UNIT_WITH_ERROR_FLAGS_ASSERT_SVH
`define MUL_DIV_UNIT_WITH_ERROR_FLAGS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MDU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MDU_ASSERT(lbl, prop, msg)
`define MDU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* design/mdu_pkg.sv */
// shared constants and types of the multiply/divide unit
// no dependencies; imported by all modules
`timescale 1ns / 1ps
package mdu_pkg;
  localparam int OPERAND_WIDTH = 64;
  localparam int FIELD_W       = 64;
  localparam int HALF_W        = OPERAND_WIDTH / 2;
  localparam int MUL_LAT       = 3;
  localparam int DIV_LAT       = OPERAND_WIDTH;
  localparam int PAD_LAT       = DIV_LAT - MUL_LAT;

  typedef enum logic [1:0] {
    OP_MUL = 2'b00,
    OP_IL1 = 2'b01,
    OP_IL2 = 2'b10,
    OP_DIV = 2'b11
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_ILLEGAL  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] lo;
    logic                     ovf;
  } mul_res_t;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] rem;
    logic [OPERAND_WIDTH-1:0] quo;
    logic [OPERAND_WIDTH-1:0] dvd;
    logic [OPERAND_WIDTH-1:0] dvs;
  } div_st_t;

  typedef struct packed {
    logic    vld;
    opcode_t op;
    logic    bz;
  } ctl_t;
endpackage

/* design/mdu_mul.sv */
// pipelined multiplier from half-width partial products, with overflow flag
// depends on mdu_pkg; the result is delayed to line up with the divider
`timescale 1ns / 1ps
module mdu_mul import mdu_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  output mul_res_t                 res
);
  logic [OPERAND_WIDTH-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [OPERAND_WIDTH-1:0]   ll2_r, hh2_r;
  logic [OPERAND_WIDTH:0]     mid_r;
  logic [2*OPERAND_WIDTH-1:0] full;
  mul_res_t                   s3_r;
  mul_res_t                   pad_r [PAD_LAT];

  // final sum of the partial products
  assign full = {hh2_r, ll2_r}
              + ({{(OPERAND_WIDTH-1){1'b0}}, mid_r} << HALF_W);

  // stage 1: partial products, stage 2: middle sum, stage 3: full product
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= a[HALF_W-1:0] * b[HALF_W-1:0];
      lh_r  <= a[HALF_W-1:0] * b[OPERAND_WIDTH-1:HALF_W];
      hl_r  <= a[OPERAND_WIDTH-1:HALF_W] * b[HALF_W-1:0];
      hh_r  <= a[OPERAND_WIDTH-1:HALF_W] * b[OPERAND_WIDTH-1:HALF_W];
      ll2_r <= ll_r;
      hh2_r <= hh_r;
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      s3_r.lo  <= full[OPERAND_WIDTH-1:0];
      s3_r.ovf <= |full[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
    end
  end

  // delay line to line up with the divider
  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= s3_r;
      for (int i = 1; i < PAD_LAT; i++) pad_r[i] <= pad_r[i-1];
    end
  end

  assign res = pad_r[PAD_LAT-1];
endmodule

/* design/mdu_div_stage.sv */
// one restoring division step: one quotient bit per stage
// depends on mdu_pkg; chained DIV_LAT times in the top level
`timescale 1ns / 1ps
module mdu_div_stage import mdu_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  div_st_t st_in,
  output div_st_t st_out
);
  logic [OPERAND_WIDTH:0] trial;
  logic [OPERAND_WIDTH:0] diff;
  div_st_t                st_r;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {st_in.rem, st_in.dvd[OPERAND_WIDTH-1]};
  assign diff  = trial - {1'b0, st_in.dvs};

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.rem <= trial[OPERAND_WIDTH] ? diff[OPERAND_WIDTH-1:0]
                : (diff[OPERAND_WIDTH] ? trial[OPERAND_WIDTH-1:0]
                                       : diff[OPERAND_WIDTH-1:0]);
      st_r.quo <= {st_in.quo[OPERAND_WIDTH-2:0],
                   trial[OPERAND_WIDTH] | ~diff[OPERAND_WIDTH]};
      st_r.dvd <= {st_in.dvd[OPERAND_WIDTH-2:0], 1'b0};
      st_r.dvs <= st_in.dvs;
    end
  end

  assign st_out = st_r;
endmodule

/* design/mul_div_unit_with_error_flags.sv */
// Unsigned multiply/divide unit. One beat per cycle enters the pipeline when
// it is not held; 64 one-bit divider stages set the depth, and the
// multiplier (three stages) is padded to the same length. Opcode 00 gives
// the low product or overflow (error 3), 11 the quotient or divide by zero
// (error 1), 01 and 10 error 2; the value is zero on any error. The whole
// pipeline holds while a result waits on out_tready.
// depends on mdu_pkg, mdu_mul, mdu_div_stage and the assertion header
`timescale 1ns / 1ps
`include "mul_div_unit_with_error_flags_assert.svh"
module mul_div_unit_with_error_flags import mdu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // opcode[1:0], operand_a[65:2], operand_b[129:66], zeros
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // product_or_quotient[63:0], error_code[65:64], zeros
);
  logic                     en;
  logic [OPERAND_WIDTH-1:0] a_in, b_in;
  ctl_t                     ctl_r [DIV_LAT];
  div_st_t                  dst [DIV_LAT+1];
  mul_res_t                 mres;
  logic                     vld_o_r;
  logic [OPERAND_WIDTH-1:0] val_r, val_nxt;
  err_t                     err_r, err_nxt;

  assign en        = !vld_o_r || out_tready;
  assign in_tready = en;
  assign a_in      = in_tdata[2+OPERAND_WIDTH-1:2];
  assign b_in      = in_tdata[2+FIELD_W+OPERAND_WIDTH-1:2+FIELD_W];

  // control line beside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) ctl_r[i].vld <= 1'b0;
    end else if (en) begin
      ctl_r[0].vld <= in_tvalid;
      ctl_r[0].op  <= opcode_t'(in_tdata[1:0]);
      ctl_r[0].bz  <= (b_in == '0);
      for (int i = 1; i < DIV_LAT; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  // divider chain
  assign dst[0].rem = '0;
  assign dst[0].quo = '0;
  assign dst[0].dvd = a_in;
  assign dst[0].dvs = b_in;

  for (genvar g = 0; g < DIV_LAT; g++) begin : g_div
    mdu_div_stage u_stage (
      .clk    (clk),
      .en     (en),
      .st_in  (dst[g]),
      .st_out (dst[g+1])
    );
  end

  // multiplier
  mdu_mul u_mul (
    .clk (clk),
    .en  (en),
    .a   (a_in),
    .b   (b_in),
    .res (mres)
  );

  // result select and error code
  always_comb begin
    val_nxt = '0;
    err_nxt = ERR_NONE;
    case (ctl_r[DIV_LAT-1].op)
      OP_MUL: begin
        if (mres.ovf) err_nxt = ERR_OVERFLOW;
        else          val_nxt = mres.lo;
      end
      OP_DIV: begin
        if (ctl_r[DIV_LAT-1].bz) err_nxt = ERR_DIV_ZERO;
        else                     val_nxt = dst[DIV_LAT].quo;
      end
      default: err_nxt = ERR_ILLEGAL;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) vld_o_r <= 1'b0;
    else if (en) vld_o_r <= ctl_r[DIV_LAT-1].vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_tvalid = vld_o_r;
  assign out_tdata  = {6'd0, err_r, val_r};

  // checks
  `MDU_ASSERT(a_err_zero, vld_o_r && (err_r != ERR_NONE) |-> (val_r == '0), "value not zero on error")
  `MDU_ASSERT(a_stall, vld_o_r && !out_tready |-> !in_tready, "input taken during stall")
  `MDU_ASSERT_RST(a_rst, !rst_n |=> !vld_o_r, "result valid after reset")
endmodule
